[rtl/csdc_pkg.sv]
// Package for the caster steer and drive command unit: constants, types and helpers.
`default_nettype none

package csdc_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int IDX_W         = 5;

  localparam int ANG_W  = 21;
  localparam int XV_W   = 36;
  localparam int XR_W   = 34;
  localparam int RY_W   = 33;
  localparam int TRIG_W = 28;

  localparam logic signed [ANG_W-1:0] PI_Q16      = ANG_W'(205887);
  localparam logic signed [ANG_W-1:0] TWO_PI_Q16  = ANG_W'(411775);
  localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = ANG_W'(102944);
  localparam logic signed [XR_W-1:0]  INV_GAIN_Q30 = XR_W'(652032875);

  localparam logic [15:0] STEER_GAIN_RST   = 16'd10240;
  localparam logic [15:0] LEVER_RADIUS_RST = 16'd32768;

  typedef enum logic [1:0] {
    CFG_STEER_GAIN   = 2'd0,
    CFG_LEVER_RADIUS = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [XV_W-1:0]  vx;
    logic signed [XV_W-1:0]  vy;
    logic signed [ANG_W-1:0] vz;
    logic signed [XR_W-1:0]  rx;
    logic signed [XR_W-1:0]  ry;
    logic signed [ANG_W-1:0] rz;
    logic                    zero;
    logic                    neg;
    logic signed [ANG_W-1:0] ang;
    logic signed [RY_W-1:0]  ry24;
    logic signed [15:0]      fwd;
  } cordic_t;

  function automatic logic signed [ANG_W-1:0] atan_q16(input logic [IDX_W-1:0] i);
    logic signed [ANG_W-1:0] r;
    case (i)
      5'd0:  r = ANG_W'(51472);
      5'd1:  r = ANG_W'(30386);
      5'd2:  r = ANG_W'(16055);
      5'd3:  r = ANG_W'(8150);
      5'd4:  r = ANG_W'(4091);
      5'd5:  r = ANG_W'(2047);
      5'd6:  r = ANG_W'(1024);
      5'd7:  r = ANG_W'(512);
      5'd8:  r = ANG_W'(256);
      5'd9:  r = ANG_W'(128);
      5'd10: r = ANG_W'(64);
      5'd11: r = ANG_W'(32);
      5'd12: r = ANG_W'(16);
      5'd13: r = ANG_W'(8);
      5'd14: r = ANG_W'(4);
      5'd15: r = ANG_W'(2);
      5'd16: r = ANG_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Two steps each way cover every difference that the datapath can form.
  function automatic logic signed [ANG_W-1:0] wrap_angle(input logic signed [ANG_W-1:0] d);
    logic signed [ANG_W-1:0] r;
    r = d;
    if (r > PI_Q16) r = r - TWO_PI_Q16;
    if (r > PI_Q16) r = r - TWO_PI_Q16;
    if (r < -PI_Q16) r = r + TWO_PI_Q16;
    if (r < -PI_Q16) r = r + TWO_PI_Q16;
    return r;
  endfunction

  function automatic logic signed [ANG_W-1:0] abs_angle(input logic signed [ANG_W-1:0] d);
    return (d < 0) ? -d : d;
  endfunction

endpackage

`default_nettype wire

[rtl/csdc_cordic_stage.sv]
// One registered iteration of both the vectoring and the rotation CORDIC.
`default_nettype none

module csdc_cordic_stage (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic [csdc_pkg::IDX_W-1:0]    idx_i,
  input  wire logic                          valid_i,
  input  wire csdc_pkg::cordic_t             data_i,
  output logic                               valid_o,
  output csdc_pkg::cordic_t                  data_o
);
  import csdc_pkg::*;

  cordic_t data_d, data_q;
  logic    valid_q;
  logic signed [ANG_W-1:0] at;

  always_comb begin
    at     = atan_q16(idx_i);
    data_d = data_i;
    if (data_i.vy > 0) begin
      data_d.vx = data_i.vx + (data_i.vy >>> idx_i);
      data_d.vy = data_i.vy - (data_i.vx >>> idx_i);
      data_d.vz = data_i.vz + at;
    end else begin
      data_d.vx = data_i.vx - (data_i.vy >>> idx_i);
      data_d.vy = data_i.vy + (data_i.vx >>> idx_i);
      data_d.vz = data_i.vz - at;
    end
    if (data_i.rz >= 0) begin
      data_d.rx = data_i.rx - (data_i.ry >>> idx_i);
      data_d.ry = data_i.ry + (data_i.rx >>> idx_i);
      data_d.rz = data_i.rz - at;
    end else begin
      data_d.rx = data_i.rx + (data_i.ry >>> idx_i);
      data_d.ry = data_i.ry - (data_i.rx >>> idx_i);
      data_d.rz = data_i.rz + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[rtl/caster_steer_drive_command_unit.sv]
// Top level of the caster steer and drive command unit.
`default_nettype none

// Each item (forward speed, turn rate, caster angle) yields one result (steer and
// drive velocity). The pipeline has one register per CORDIC iteration plus input,
// set-up, angle error, multiply and rounding stages; a new item is taken every cycle,
// and the whole pipeline holds while a result waits.
// Configuration writes take effect at once and should be made only while the unit is
// empty; writes to unknown indexes are ignored.
module caster_steer_drive_command_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] forward_speed_i,
  input  wire logic signed [15:0] turn_rate_i,
  input  wire logic signed [15:0] caster_angle_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [23:0]      steer_velocity_o,
  output logic signed [19:0]      drive_velocity_o
);
  import csdc_pkg::*;

  logic [15:0] gain_q, radius_q;
  logic        en;

  // Input stage.
  logic                    v1_q;
  logic signed [15:0]      fwd1_q;
  logic signed [RY_W-1:0]  ry1_q;
  logic signed [ANG_W-1:0] ang1_q;

  // Set-up stage and CORDIC chain.
  cordic_t prep_d;
  logic    vc [CORDIC_STAGES+1];
  cordic_t dc [CORDIC_STAGES+1];
  logic signed [XV_W-1:0]  px, py;
  logic signed [ANG_W-1:0] pa;

  // Angle error stage.
  logic                    va_q;
  logic signed [ANG_W-1:0] e1_q, e2_q, e1_d, e2_d, h;
  logic signed [TRIG_W-1:0] sn_q, cs_q;
  logic signed [XR_W-1:0]  cx, cy;
  logic signed [RY_W-1:0]  rya_q;
  logic signed [15:0]      fwda_q;

  // Multiply stage.
  logic                    vb_q;
  logic signed [ANG_W-1:0] err;
  logic signed [37:0]      sp_q;
  logic signed [60:0]      pr_q;
  logic signed [43:0]      pf_q;

  // Output stage.
  logic                    out_valid_q;
  logic signed [23:0]      steer_q, steer_d;
  logic signed [19:0]      drive_q, drive_d;
  logic signed [37:0]      st_sum, st_sh;
  logic signed [62:0]      dr_sum, dr_sh;

  assign en          = ~out_valid_q | out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= STEER_GAIN_RST;
      radius_q <= LEVER_RADIUS_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_STEER_GAIN)   gain_q   <= cfg_data_i;
      if (cfg_index_i == CFG_LEVER_RADIUS) radius_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      vc[0]       <= 1'b0;
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      vc[0]       <= v1_q;
      va_q        <= vc[CORDIC_STAGES];
      vb_q        <= va_q;
      out_valid_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fwd1_q <= forward_speed_i;
      ry1_q  <= RY_W'($signed(turn_rate_i) * $signed({1'b0, radius_q}));
      ang1_q <= {{2{caster_angle_i[15]}}, caster_angle_i, 3'b000};
    end
  end

  // Set-up: half-plane fold for the heading, half-plane fold for sine and cosine.
  always_comb begin
    px = {{(XV_W-32){fwd1_q[15]}}, fwd1_q, 16'h0000};
    py = -XV_W'(ry1_q);
    prep_d      = '0;
    prep_d.zero = (fwd1_q == 0) && (ry1_q == 0);
    prep_d.vx   = px;
    prep_d.vy   = py;
    prep_d.vz   = '0;
    if (fwd1_q < 0) begin
      prep_d.vz = (py >= 0) ? PI_Q16 : -PI_Q16;
      prep_d.vx = -px;
      prep_d.vy = -py;
    end
    pa         = wrap_angle(ang1_q);
    prep_d.neg = 1'b0;
    if (pa > HALF_PI_Q16) begin
      pa         = pa - PI_Q16;
      prep_d.neg = 1'b1;
    end else if (pa < -HALF_PI_Q16) begin
      pa         = pa + PI_Q16;
      prep_d.neg = 1'b1;
    end
    prep_d.rx   = INV_GAIN_Q30;
    prep_d.ry   = '0;
    prep_d.rz   = pa;
    prep_d.ang  = ang1_q;
    prep_d.ry24 = ry1_q;
    prep_d.fwd  = fwd1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dc[0] <= prep_d;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    csdc_cordic_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (IDX_W'(g)),
      .valid_i (vc[g]),
      .data_i  (dc[g]),
      .valid_o (vc[g+1]),
      .data_o  (dc[g+1])
    );
  end

  always_comb begin
    h    = dc[CORDIC_STAGES].zero ? '0 : dc[CORDIC_STAGES].vz;
    e1_d = wrap_angle(dc[CORDIC_STAGES].ang - h);
    e2_d = wrap_angle(dc[CORDIC_STAGES].ang - h - PI_Q16);
    cx   = dc[CORDIC_STAGES].neg ? -dc[CORDIC_STAGES].rx : dc[CORDIC_STAGES].rx;
    cy   = dc[CORDIC_STAGES].neg ? -dc[CORDIC_STAGES].ry : dc[CORDIC_STAGES].ry;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_q   <= e1_d;
      e2_q   <= e2_d;
      cs_q   <= cx[XR_W-1:6];
      sn_q   <= cy[XR_W-1:6];
      rya_q  <= dc[CORDIC_STAGES].ry24;
      fwda_q <= dc[CORDIC_STAGES].fwd;
    end
  end

  // On a tie the unflipped heading is kept.
  assign err = (abs_angle(e1_q) > abs_angle(e2_q)) ? e2_q : e1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sp_q <= 38'($signed({1'b0, gain_q}) * err);
      pr_q <= 61'(rya_q * sn_q);
      pf_q <= 44'(fwda_q * cs_q);
    end
  end

  always_comb begin
    st_sum = -sp_q + 38'sd32768;
    st_sh  = st_sum >>> 16;
    if (st_sh > 38'sh7FFFFF) begin
      steer_d = 24'sh7FFFFF;
    end else if (st_sh < -38'sh800000) begin
      steer_d = -24'sh800000;
    end else begin
      steer_d = st_sh[23:0];
    end
    dr_sum = 63'(pr_q) - (63'(pf_q) <<< 16) + (63'sd1 <<< 39);
    dr_sh  = dr_sum >>> 40;
    if (dr_sh > 63'sh7FFFF) begin
      drive_d = 20'sh7FFFF;
    end else if (dr_sh < -63'sh80000) begin
      drive_d = -20'sh80000;
    end else begin
      drive_d = dr_sh[19:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      steer_q <= steer_d;
      drive_q <= drive_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign steer_velocity_o = steer_q;
  assign drive_velocity_o = drive_q;

endmodule

`default_nettype wire

[test/caster_steer_drive_command_unit_test.sv]
// Testbench for the caster steer and drive command unit: predicts and checks every result.
`default_nettype none

module caster_steer_drive_command_unit_test;
  import csdc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTAGE = CORDIC_STAGES;
  localparam longint PI_A = 205887;
  localparam longint TWO_PI_A = 411775;
  localparam longint HALF_PI_A = 102944;

  typedef struct {
    logic signed [23:0] steer;
    logic signed [19:0] drive;
  } command_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic signed [15:0] forward_speed_i = '0;
  logic signed [15:0] turn_rate_i = '0;
  logic signed [15:0] caster_angle_i = '0;
  logic out_ready_i = 1'b0;
  wire cfg_ready_o, in_ready_o, out_valid_o;
  wire signed [23:0] steer_velocity_o;
  wire signed [19:0] drive_velocity_o;

  logic [15:0] gain_reg = STEER_GAIN_RST;
  logic [15:0] radius_reg = LEVER_RADIUS_RST;
  command_t pending_cmds[$];
  int errors = 0;
  int checked = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  caster_steer_drive_command_unit dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint wrap_pi(longint d);
    while (d > PI_A) d -= TWO_PI_A;
    while (d < -PI_A) d += TWO_PI_A;
    return d;
  endfunction

  function automatic longint arctan_step(int i);
    longint tbl[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 17) ? tbl[i] : 0;
  endfunction

  function automatic longint heading(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_A : -PI_A;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < NSTAGE; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += arctan_step(i);
      end else begin
        x -= dx; y += dy; z -= arctan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic command_t predict_command(logic signed [15:0] fwd,
                                               logic signed [15:0] turn,
                                               logic signed [15:0] angle);
    command_t r;
    longint ang, vx24, ry24, h, e1, e2, err, st, dr, x, y, z, dx, dy;
    bit neg;
    ang = longint'(angle) * 8;
    vx24 = longint'(fwd) * 65536;
    ry24 = longint'(turn) * longint'(radius_reg);
    h = heading(vx24, -ry24);
    e1 = wrap_pi(ang - h);
    e2 = wrap_pi(ang - h - PI_A);
    err = ((e1 < 0 ? -e1 : e1) > (e2 < 0 ? -e2 : e2)) ? e2 : e1;
    st = fshift(-(longint'(gain_reg) * err) + 32768, 16);
    // Rotation CORDIC on the caster angle, folded into the right half plane.
    z = wrap_pi(ang);
    neg = 1'b0;
    if (z > HALF_PI_A) begin
      z -= PI_A; neg = 1'b1;
    end else if (z < -HALF_PI_A) begin
      z += PI_A; neg = 1'b1;
    end
    x = 652032875;
    y = 0;
    for (int i = 0; i < NSTAGE; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    if (neg) begin
      x = -x; y = -y;
    end
    x = fshift(x, 6);
    y = fshift(y, 6);
    dr = fshift(ry24 * y - vx24 * x + (longint'(1) << 39), 40);
    r.steer = 24'(sat(st, -8388608, 8388607));
    r.drive = 20'(sat(dr, -524288, 524287));
    return r;
  endfunction

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic send_command(logic signed [15:0] fwd, logic signed [15:0] turn,
                              logic signed [15:0] angle);
    idle_gap();
    in_valid_i <= 1'b1;
    forward_speed_i <= fwd;
    turn_rate_i <= turn;
    caster_angle_i <= angle;
    pending_cmds.push_back(predict_command(fwd, turn, angle));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (NSTAGE + 10) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_STEER_GAIN) gain_reg = value;
    else if (idx == CFG_LEVER_RADIUS) radius_reg = value;
    @(posedge clk_i);
  endtask

  // The receiver stalls in bursts until the final part of the run.
  always @(posedge clk_i) begin
    if (calm) begin
      out_ready_i <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      stall_left <= int'($urandom_range(0, 16));
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    command_t exp_cmd;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected result steer %0d drive %0d", $time,
                 steer_velocity_o, drive_velocity_o);
        errors++;
      end else begin
        exp_cmd = pending_cmds.pop_front();
        checked++;
        if (steer_velocity_o !== exp_cmd.steer) begin
          $display("%0t: steer expected %0d actual %0d", $time, exp_cmd.steer,
                   steer_velocity_o);
          errors++;
        end
        if (drive_velocity_o !== exp_cmd.drive) begin
          $display("%0t: drive expected %0d actual %0d", $time, exp_cmd.drive,
                   drive_velocity_o);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [15:0] rand_angle();
    return 16'($signed($urandom_range(0, 51472)) - 25736);
  endfunction

  function automatic logic signed [15:0] rand_speed();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 1024)) - 512);
      2: return ($urandom_range(0, 1)) ? 16'sh7fff : -16'sh8000;
      default: return 16'sd0;
    endcase
  endfunction

  task automatic test_directed();
    logic signed [15:0] speeds[5] = '{-16'sh8000, -16'sd256, 16'sd0, 16'sd256, 16'sh7fff};
    send_command(0, 0, 0);
    send_command(0, 0, 16'sd25736);
    send_command(0, 0, -16'sd25736);
    send_command(16'sd256, 0, 16'sd12868);
    send_command(16'sd256, 0, -16'sd12868);
    send_command(-16'sh8000, -16'sh8000, 16'sh7fff);
    send_command(16'sh7fff, 16'sh7fff, -16'sh8000);
    send_command(-16'sh8000, 16'sh7fff, 16'sh5555);
    send_command(16'sh7fff, -16'sh8000, -16'sh2aab);
    foreach (speeds[i]) send_command(speeds[i], speeds[4 - i], 16'(i * 5000 - 10000));
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++)
      send_command(rand_speed(), rand_speed(),
                   ($urandom_range(0, 9) == 0) ? 16'($urandom) : rand_angle());
  endtask

  task automatic test_settings();
    logic [15:0] gains[4] = '{16'd0, 16'hffff, 16'd256, 16'd10240};
    logic [15:0] radii[4] = '{16'hffff, 16'd0, 16'd1, 16'd32768};
    for (int s = 0; s < 4; s++) begin
      drain();
      write_register(CFG_STEER_GAIN, gains[s]);
      write_register(CFG_LEVER_RADIUS, radii[s]);
      test_random(150);
    end
    drain();
    write_register(CFG_STEER_GAIN, 16'($urandom));
    write_register(CFG_LEVER_RADIUS, 16'($urandom));
    test_random(100);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(250);
    test_settings();
    calm = 1'b1;
    test_random(100);
    drain();
    $display("Checked %0d results over six gain and radius settings,", checked);
    $display("including extreme commands, zero commands and wrapped angles.");
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/csdc_pkg.sv
rtl/csdc_cordic_stage.sv
rtl/caster_steer_drive_command_unit.sv
test/caster_steer_drive_command_unit_test.sv
